>>> hdl/btpc_pkg.sv
// Package: shared constants, types and register indexes for the compensation block
`timescale 1ns / 1ps
package btpc_pkg;
    localparam logic [15:0] AC1_RST = 16'd408;
    localparam logic [15:0] AC2_RST = 16'hFFB8;
    localparam logic [15:0] AC3_RST = 16'hC7D1;
    localparam logic [15:0] AC4_RST = 16'd32741;
    localparam logic [15:0] AC5_RST = 16'd32757;
    localparam logic [15:0] AC6_RST = 16'd23153;
    localparam logic [31:0] B1B2_RST = 32'd405667844;
    localparam logic [31:0] MCMD_RST = 32'd3724086068;

    localparam logic [2:0] REG_AC1  = 3'd0;
    localparam logic [2:0] REG_AC2  = 3'd1;
    localparam logic [2:0] REG_AC3  = 3'd2;
    localparam logic [2:0] REG_AC4  = 3'd3;
    localparam logic [2:0] REG_AC5  = 3'd4;
    localparam logic [2:0] REG_AC6  = 3'd5;
    localparam logic [2:0] REG_B1B2 = 3'd6;
    localparam logic [2:0] REG_MCMD = 3'd7;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [31:0] b1b2;
        logic [31:0] mcmd;
    } t_cal;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        asr = 32'($signed(x) >>> n);
    endfunction
endpackage

>>> hdl/btpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, 32-bit unsigned
`timescale 1ns / 1ps
module btpc_div #(
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [31:0]      i_num,
    input  logic [31:0]      i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [31:0]      o_quo,
    output logic [TAG_W-1:0] o_tag
);
    logic [32:0]      r_rem [0:32];
    logic [31:0]      r_num [0:32];
    logic [31:0]      r_den [0:32];
    logic [TAG_W-1:0] r_tag [0:32];
    logic             r_vld [0:32];

    always_comb begin
        r_rem[0] = '0;
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
        r_vld[0] = i_vld;
    end

    for (genvar k = 0; k < 32; k++) begin : g_stage
        logic [32:0] n_sh;
        logic [32:0] n_sub;
        assign n_sh  = {r_rem[k][31:0], r_num[k][31]};
        assign n_sub = n_sh - {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_rem[k+1] <= n_sub[32] ? n_sh : n_sub;
                r_num[k+1] <= {r_num[k][30:0], ~n_sub[32]};
                r_den[k+1] <= r_den[k];
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_vld = r_vld[32];
    assign o_quo = r_num[32];
    assign o_tag = r_tag[32];
endmodule

>>> hdl/btpc_cfg.sv
// Calibration register file
`timescale 1ns / 1ps
module btpc_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output btpc_pkg::t_cal   o_cal
);
    btpc_pkg::t_cal r_cal;
    assign o_cfg_ready = 1'b1;
    assign o_cal = r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.ac1  <= btpc_pkg::AC1_RST;
            r_cal.ac2  <= btpc_pkg::AC2_RST;
            r_cal.ac3  <= btpc_pkg::AC3_RST;
            r_cal.ac4  <= btpc_pkg::AC4_RST;
            r_cal.ac5  <= btpc_pkg::AC5_RST;
            r_cal.ac6  <= btpc_pkg::AC6_RST;
            r_cal.b1b2 <= btpc_pkg::B1B2_RST;
            r_cal.mcmd <= btpc_pkg::MCMD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                btpc_pkg::REG_AC1:  r_cal.ac1  <= i_cfg_data[15:0];
                btpc_pkg::REG_AC2:  r_cal.ac2  <= i_cfg_data[15:0];
                btpc_pkg::REG_AC3:  r_cal.ac3  <= i_cfg_data[15:0];
                btpc_pkg::REG_AC4:  r_cal.ac4  <= i_cfg_data[15:0];
                btpc_pkg::REG_AC5:  r_cal.ac5  <= i_cfg_data[15:0];
                btpc_pkg::REG_AC6:  r_cal.ac6  <= i_cfg_data[15:0];
                btpc_pkg::REG_B1B2: r_cal.b1b2 <= i_cfg_data;
                default:            r_cal.mcmd <= i_cfg_data;
            endcase
        end
    end
endmodule

>>> hdl/baro_temp_pressure_compensation.sv
// Top level: pipelined temperature and pressure compensation
// Throughput: one item per cycle while not stalled; two 32-stage dividers set the depth.
// A stall on the output freezes the whole pipeline while the output register is
// full; the output register holds the last result. Synchronous active-low reset
// clears valid bits and restores calibration reset values.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_raw_temp,
    input  logic [15:0] i_raw_press,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_temp_tenths,
    output logic [31:0] o_press_pa,
    output logic        o_div_zero,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    btpc_pkg::t_cal cal;
    logic en;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    btpc_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_cal(cal)
    );

    assign ac1 = btpc_pkg::sx16(cal.ac1);
    assign ac2 = btpc_pkg::sx16(cal.ac2);
    assign ac3 = btpc_pkg::sx16(cal.ac3);
    assign ac4 = {16'd0, cal.ac4};
    assign ac5 = {16'd0, cal.ac5};
    assign ac6 = {16'd0, cal.ac6};
    assign b1  = btpc_pkg::sx16(cal.b1b2[31:16]);
    assign b2  = btpc_pkg::sx16(cal.b1b2[15:0]);
    assign mc  = btpc_pkg::sx16(cal.mcmd[31:16]);
    assign md  = btpc_pkg::sx16(cal.mcmd[15:0]);

    // output skid: en freezes the pipe when the output register is full and stalled
    logic        r_ov;
    logic [31:0] r_ot, r_op;
    logic        r_oz;
    assign en = !r_ov || !i_stall;
    assign o_stall = !en;

    // stage 1: temperature product
    logic        r1_v;
    logic [31:0] r1_x1m;
    logic [15:0] r1_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_valid;
        if (en) begin
            r1_x1m <= ({16'd0, i_raw_temp} - ac6) * ac5;
            r1_up  <= i_raw_press;
        end
    end

    // stage 2: divisor and sign handling for x2 = (mc<<11)/den
    logic        r2_v, r2_dz, r2_neg;
    logic [31:0] r2_x1, r2_an, r2_ad;
    logic [15:0] r2_up;
    logic [31:0] n2_x1, n2_den, n2_num;
    always_comb begin
        n2_x1  = btpc_pkg::asr(r1_x1m, 15);
        n2_den = n2_x1 + md;
        n2_num = mc << 11;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
        if (en) begin
            r2_x1  <= n2_x1;
            r2_dz  <= (n2_den == 32'd0);
            r2_neg <= n2_num[31] ^ n2_den[31];
            r2_an  <= n2_num[31] ? 32'(-n2_num) : n2_num;
            r2_ad  <= n2_den[31] ? 32'(-n2_den) : ((n2_den == 0) ? 32'd1 : n2_den);
            r2_up  <= r1_up;
        end
    end

    localparam int TAG1 = 1 + 1 + 32 + 16;
    logic            d1_v;
    logic [31:0]     d1_q;
    logic [TAG1-1:0] d1_t;
    btpc_div #(.TAG_W(TAG1)) u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r2_v),
        .i_num(r2_an), .i_den(r2_ad), .i_tag({r2_dz, r2_neg, r2_x1, r2_up}),
        .o_vld(d1_v), .o_quo(d1_q), .o_tag(d1_t)
    );

    // stage 3: b5, t, b6
    logic        r3_v, r3_dz;
    logic [31:0] r3_t, r3_b6;
    logic [15:0] r3_up;
    logic [31:0] n3_x2, n3_b5;
    always_comb begin
        n3_x2 = d1_t[48] ? 32'(-d1_q) : d1_q;
        n3_b5 = d1_t[47:16] + n3_x2;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= d1_v;
        if (en) begin
            r3_dz <= d1_t[49];
            r3_t  <= btpc_pkg::asr(n3_b5 + 32'd8, 4);
            r3_b6 <= n3_b5 - 32'd4000;
            r3_up <= d1_t[15:0];
        end
    end

    // stage 4: b6 squared and linear products
    logic        r4_v, r4_dz;
    logic [31:0] r4_t, r4_sqm, r4_a2, r4_a3;
    logic [15:0] r4_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
        if (en) begin
            r4_dz  <= r3_dz;
            r4_t   <= r3_t;
            r4_up  <= r3_up;
            r4_sqm <= r3_b6 * r3_b6;
            r4_a2  <= btpc_pkg::asr(ac2 * r3_b6, 11);
            r4_a3  <= btpc_pkg::asr(ac3 * r3_b6, 13);
        end
    end

    // stage 5: b2*sq, b1*sq
    logic        r5_v, r5_dz;
    logic [31:0] r5_t, r5_a2, r5_a3, r5_p2, r5_p1;
    logic [15:0] r5_up;
    logic [31:0] n5_sq;
    assign n5_sq = btpc_pkg::asr(r4_sqm, 12);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
        if (en) begin
            r5_dz <= r4_dz;
            r5_t  <= r4_t;
            r5_up <= r4_up;
            r5_a2 <= r4_a2;
            r5_a3 <= r4_a3;
            r5_p2 <= btpc_pkg::asr(b2 * n5_sq, 11);
            r5_p1 <= btpc_pkg::asr(b1 * n5_sq, 16);
        end
    end

    // stage 6: b3 and x3
    logic        r6_v, r6_dz;
    logic [31:0] r6_t, r6_b3, r6_x3;
    logic [15:0] r6_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
        if (en) begin
            r6_dz <= r5_dz;
            r6_t  <= r5_t;
            r6_up <= r5_up;
            r6_b3 <= btpc_pkg::asr((ac1 << 2) + r5_p2 + r5_a2 + 32'd2, 2);
            r6_x3 <= btpc_pkg::asr(r5_a3 + r5_p1 + 32'd2, 2);
        end
    end

    // stage 7: b4 and b7 products
    logic        r7_v, r7_dz;
    logic [31:0] r7_t, r7_b4m, r7_b7;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r6_v;
        if (en) begin
            r7_dz  <= r6_dz;
            r7_t   <= r6_t;
            r7_b4m <= ac4 * (r6_x3 + 32'd32768);
            r7_b7  <= ({16'd0, r6_up} - r6_b3) * 32'd50000;
        end
    end

    // stage 8: divider operands
    logic        r8_v, r8_dz, r8_hi;
    logic [31:0] r8_t, r8_num, r8_den;
    logic [31:0] n8_b4;
    assign n8_b4 = r7_b4m >> 15;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en) r8_v <= r7_v;
        if (en) begin
            r8_dz  <= r7_dz || (n8_b4 == 32'd0);
            r8_t   <= r7_t;
            r8_hi  <= r7_b7[31];
            r8_num <= r7_b7[31] ? r7_b7 : (r7_b7 << 1);
            r8_den <= (n8_b4 == 32'd0) ? 32'd1 : n8_b4;
        end
    end

    localparam int TAG2 = 1 + 1 + 32;
    logic            d2_v;
    logic [31:0]     d2_q;
    logic [TAG2-1:0] d2_t;
    btpc_div #(.TAG_W(TAG2)) u_div_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r8_v),
        .i_num(r8_num), .i_den(r8_den), .i_tag({r8_dz, r8_hi, r8_t}),
        .o_vld(d2_v), .o_quo(d2_q), .o_tag(d2_t)
    );

    // stage 9: p and correction products
    logic        r9_v, r9_dz;
    logic [31:0] r9_t, r9_p, r9_s, r9_c2;
    logic [31:0] n9_p;
    assign n9_p = d2_t[32] ? (d2_q << 1) : d2_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (en) r9_v <= d2_v;
        if (en) begin
            r9_dz <= d2_t[33];
            r9_t  <= d2_t[31:0];
            r9_p  <= n9_p;
            r9_s  <= btpc_pkg::asr(n9_p, 8) * btpc_pkg::asr(n9_p, 8);
            r9_c2 <= btpc_pkg::asr(32'hFFFF_E343 * n9_p, 16);
        end
    end

    // stage 10: x1*3038
    logic        r10_v, r10_dz;
    logic [31:0] r10_t, r10_p, r10_c1, r10_c2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (en) r10_v <= r9_v;
        if (en) begin
            r10_dz <= r9_dz;
            r10_t  <= r9_t;
            r10_p  <= r9_p;
            r10_c2 <= r9_c2;
            r10_c1 <= btpc_pkg::asr(r9_s * 32'd3038, 16);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= r10_v;
        if (en) begin
            r_oz <= r10_dz;
            r_ot <= r10_dz ? 32'd0 : r10_t;
            r_op <= r10_dz ? 32'd0
                  : r10_p + btpc_pkg::asr(r10_c1 + r10_c2 + 32'd3791, 4);
        end
    end

    assign o_valid       = r_ov;
    assign o_temp_tenths = r_ot;
    assign o_press_pa    = r_op;
    assign o_div_zero    = r_oz;
endmodule
